// File: hdl/srs_pkg.sv
// shared types and constants for the sorted range search block
// no dependencies; used by srs_search and sorted_range_search_top
`default_nettype none

package srs_pkg;

	// default store depth and fixed payload widths
	localparam int DEPTH_DEFAULT = 1024;
	localparam int VAL_W         = 32;
	localparam int IDX_W         = 11;

	// input mode codes
	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// search controller states
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_STEP  = 4'b0100,
		S_DONE  = 4'b1000
	} srs_state_t;

	// query request from the front end to the search engine
	typedef struct packed {
		logic                    go;
		logic signed [VAL_W-1:0] target;
	} srs_req_t;

	// search answer; indices as all ones when absent
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] last;
	} srs_rsp_t;

endpackage

`default_nettype wire

// File: hdl/srs_ram.sv
// element store: simple dual-port ram, one write and one registered read port
// no package dependencies
`default_nettype none

module srs_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/srs_search.sv
// two-pass binary search engine: lowest then highest index of a target
// depends on srs_pkg; drives the read port of srs_ram
`default_nettype none

module srs_search #(
	parameter int DEPTH = srs_pkg::DEPTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire srs_pkg::srs_req_t               req,
	input  wire logic [$clog2(DEPTH+1)-1:0]      count,
	output logic                                 busy,
	output logic                                 rd_en,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	input  wire logic [srs_pkg::VAL_W-1:0]       rd_data,
	output srs_pkg::srs_rsp_t                    rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = CW + 1;
	localparam int IW = srs_pkg::IDX_W;

	srs_pkg::srs_state_t state_q;

	logic signed [SW-1:0]             lo_q, hi_q, hi_init_q;
	logic signed [srs_pkg::VAL_W-1:0] target_q;
	logic [AW-1:0]                    mid_q;
	logic [AW-1:0]                    found_q;
	logic                             found_vld_q;
	logic                             pass_q;
	logic [IW-1:0]                    first_q, last_q;

	logic signed [SW-1:0] mid_ext;
	logic signed [SW-1:0] lo_n, hi_n, lo_sel, hi_sel;
	logic [AW-1:0]        found_n;
	logic                 found_vld_n;
	logic                 eq, gt, cont, open_q;
	logic [SW:0]          mid_sum;
	logic [SW-1:0]        mid_full;
	logic [IW+AW-1:0]     found_wide;
	logic [IW-1:0]        found_idx;

	// compare the element read for mid_q and narrow the interval
	always_comb begin
		mid_ext     = $signed(SW'(mid_q));
		eq          = rd_data == target_q;
		gt          = $signed(rd_data) > target_q;
		lo_n        = lo_q;
		hi_n        = hi_q;
		found_n     = found_q;
		found_vld_n = found_vld_q;
		if (eq) begin
			found_n     = mid_q;
			found_vld_n = 1'b1;
			if (pass_q) begin
				lo_n = mid_ext + SW'(1);
			end else begin
				hi_n = mid_ext - SW'(1);
			end
		end else if (gt) begin
			hi_n = mid_ext - SW'(1);
		end else begin
			lo_n = mid_ext + SW'(1);
		end
		cont   = lo_n <= hi_n;
		open_q = lo_q <= hi_q;
	end

	// midpoint of the live interval and the read request
	always_comb begin
		if (state_q == srs_pkg::S_STEP) begin
			lo_sel = lo_n;
			hi_sel = hi_n;
		end else begin
			lo_sel = lo_q;
			hi_sel = hi_q;
		end
		mid_sum  = {lo_sel[SW-1], lo_sel} + {hi_sel[SW-1], hi_sel};
		mid_full = mid_sum[SW:1];
		rd_addr  = mid_full[AW-1:0];
		rd_en    = ((state_q == srs_pkg::S_ISSUE) && open_q) ||
		           ((state_q == srs_pkg::S_STEP) && cont);
	end

	// found index in the low bits of the reported width
	assign found_wide = {{IW{1'b0}}, found_q};
	assign found_idx  = found_wide[IW-1:0];

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srs_pkg::S_IDLE;
			pass_q      <= 1'b0;
			found_vld_q <= 1'b0;
		end else begin
			case (state_q)
				srs_pkg::S_IDLE: begin
					if (req.go) begin
						state_q     <= srs_pkg::S_ISSUE;
						pass_q      <= 1'b0;
						found_vld_q <= 1'b0;
					end
				end
				srs_pkg::S_ISSUE: begin
					if (open_q) begin
						state_q <= srs_pkg::S_STEP;
					end else if (!pass_q && found_vld_q) begin
						pass_q      <= 1'b1;
						found_vld_q <= 1'b0;
					end else begin
						state_q <= srs_pkg::S_DONE;
					end
				end
				srs_pkg::S_STEP: begin
					found_vld_q <= found_vld_n;
					if (!cont) begin
						state_q <= srs_pkg::S_ISSUE;
					end
				end
				srs_pkg::S_DONE: begin
					state_q <= srs_pkg::S_IDLE;
				end
				default: begin
					state_q <= srs_pkg::S_IDLE;
				end
			endcase
		end
	end

	// interval, target and answer registers
	always_ff @(posedge clk) begin
		case (state_q)
			srs_pkg::S_IDLE: begin
				if (req.go) begin
					target_q  <= req.target;
					lo_q      <= '0;
					hi_q      <= $signed(SW'(count)) - SW'(1);
					hi_init_q <= $signed(SW'(count)) - SW'(1);
				end
			end
			srs_pkg::S_ISSUE: begin
				if (open_q) begin
					mid_q <= rd_addr;
				end else if (!pass_q && found_vld_q) begin
					first_q <= found_idx;
					lo_q    <= '0;
					hi_q    <= hi_init_q;
				end else if (!pass_q) begin
					first_q <= '1;
					last_q  <= '1;
				end else begin
					last_q <= found_vld_q ? found_idx : '1;
				end
			end
			srs_pkg::S_STEP: begin
				lo_q    <= lo_n;
				hi_q    <= hi_n;
				found_q <= found_n;
				if (cont) begin
					mid_q <= rd_addr;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = state_q != srs_pkg::S_IDLE;
	assign rsp.valid = state_q == srs_pkg::S_DONE;
	assign rsp.first = first_q;
	assign rsp.last  = last_q;

`ifndef SYNTHESIS
	// a result strobe lasts one cycle
	a_rsp_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |=> !rsp.valid)
		else $error("result strobe held for more than one cycle");

	// reads stay inside the loaded elements
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (CW'(rd_addr) < count))
		else $error("read beyond loaded elements");

	// an absent target reports absent for both edges
	a_absent_both: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.first == '1)) |-> (rsp.last == '1))
		else $error("last index found without first index");

	// an accepted query leaves idle on the next cycle
	a_go_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req.go && !busy) |=> (state_q == srs_pkg::S_ISSUE))
		else $error("query transfer did not start the search");
`endif

endmodule

`default_nettype wire

// File: hdl/sorted_range_search_top.sv
// top level of the sorted range search block: appends, counters, ports
// depends on srs_pkg, srs_ram and srs_search
`default_nettype none

// Usage
//  A transfer is taken at a rising edge where start is high and busy is low.
//  mode selects append (store value at the next free slot; restart first
//  empties the store and clears the overflow flag) or query (find value).
//  An append gives no result; busy stays low.
//  A query raises busy and runs two binary searches over the loaded
//  elements, one element read per cycle from the store memory. An absent
//  target needs only the first search.
//  The result appears on first_index, last_index and overflowed for one
//  cycle with result_valid high; it cannot be held off, and busy drops in
//  the next cycle. Indices are all ones when the target is absent.
//  Appends past DEPTH elements are dropped and set overflowed.
//  Reset empties the store and clears the overflow flag; store contents
//  are not cleared and no clearing pass is needed.
module sorted_range_search_top #(
	parameter int DEPTH = srs_pkg::DEPTH_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             mode,
	input  wire logic signed [srs_pkg::VAL_W-1:0] value,
	input  wire logic                             restart,
	output logic                                  result_valid,
	output logic signed [srs_pkg::IDX_W-1:0]      first_index,
	output logic signed [srs_pkg::IDX_W-1:0]      last_index,
	output logic                                  overflowed
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CW-1:0]       count_q;
	logic                overflow_q;
	logic                accept, append;
	logic [CW-1:0]       base;
	logic                room;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [srs_pkg::VAL_W-1:0] rd_data;
	srs_pkg::srs_req_t   req;
	srs_pkg::srs_rsp_t   rsp;

	// input transfer decode
	assign accept = start && !busy;
	assign append = accept && (mode == srs_pkg::MODE_APPEND);
	assign base   = restart ? '0 : count_q;
	assign room   = base != CW'(DEPTH);

	assign req.go     = accept && (mode == srs_pkg::MODE_QUERY);
	assign req.target = value;

	// element count and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (append) begin
			if (room) begin
				count_q <= base + CW'(1);
			end
			overflow_q <= restart ? 1'b0 : (overflow_q || !room);
		end
	end

	srs_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (srs_pkg::VAL_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (append && room),
		.wr_addr (base[AW-1:0]),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	srs_search #(
		.DEPTH (DEPTH)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.count   (count_q),
		.busy    (busy),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rsp     (rsp)
	);

	// result ports
	assign result_valid = rsp.valid;
	assign first_index  = $signed(rsp.first);
	assign last_index   = $signed(rsp.last);
	assign overflowed   = overflow_q;

endmodule

`default_nettype wire

// File: test/tb_sorted_range_search_top.sv
// self-checking testbench for sorted_range_search_top: appends and first/last queries
// depends on srs_pkg and the sorted_range_search_top rtl, which needs srs_ram and srs_search
`default_nettype none

module tb_sorted_range_search_top;

	localparam int VAL_W       = srs_pkg::VAL_W;
	localparam int IDX_W       = srs_pkg::IDX_W;
	localparam int STORE_DEPTH = srs_pkg::DEPTH_DEFAULT;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	// one expected query answer
	typedef struct packed {
		logic signed [IDX_W-1:0] first;
		logic signed [IDX_W-1:0] last;
		logic                    ovf;
	} search_answer_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    start        = 1'b0;
	logic                    mode         = srs_pkg::MODE_APPEND;
	logic signed [VAL_W-1:0] value        = '0;
	logic                    restart      = 1'b0;
	logic                    busy;
	logic                    result_valid;
	logic signed [IDX_W-1:0] first_index;
	logic signed [IDX_W-1:0] last_index;
	logic                    overflowed;

	// shadow copy of the element store and its flags
	logic signed [VAL_W-1:0] model_elems [STORE_DEPTH];
	int                      model_count  = 0;
	logic                    model_ovf    = 1'b0;

	search_answer_t pending_answers [$];

	int  transfers_sent  = 0;
	int  answers_checked = 0;
	int  appends_dropped = 0;
	int  mismatch_count  = 0;
	bit  gaps_on         = 1'b1;

	sorted_range_search_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.value        (value),
		.restart      (restart),
		.result_valid (result_valid),
		.first_index  (first_index),
		.last_index   (last_index),
		.overflowed   (overflowed)
	);

	// 10 unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// binary search over the shadow store; upward keeps stepping right on a match
	function automatic int locate_edge(input logic signed [VAL_W-1:0] target, input bit upward);
		int lo;
		int hi;
		int mid;
		int found;
		lo    = 0;
		hi    = model_count - 1;
		found = -1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (model_elems[mid] == target) begin
				found = mid;
				if (upward)
					lo = mid + 1;
				else
					hi = mid - 1;
			end else if (model_elems[mid] > target) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return found;
	endfunction

	// update the shadow store for one accepted transfer, queue any answer
	task automatic apply_to_model(input logic op, input logic signed [VAL_W-1:0] v,
	                              input logic rs);
		search_answer_t want;
		int lo_idx;
		int hi_idx;
		if (op == srs_pkg::MODE_APPEND) begin
			if (rs) begin
				model_count = 0;
				model_ovf   = 1'b0;
			end
			if (model_count < STORE_DEPTH) begin
				model_elems[model_count] = v;
				model_count++;
			end else begin
				model_ovf = 1'b1;
				appends_dropped++;
			end
		end else begin
			lo_idx = locate_edge(v, 1'b0);
			hi_idx = (lo_idx == -1) ? -1 : locate_edge(v, 1'b1);
			want.first = IDX_W'(lo_idx);
			want.last  = IDX_W'(hi_idx);
			want.ovf   = model_ovf;
			pending_answers.push_back(want);
		end
	endtask

	// idle now and then, drive one transfer and hold it until busy is low at an edge
	task automatic send_transfer(input logic op, input logic signed [VAL_W-1:0] v,
	                             input logic rs);
		while (gaps_on && $urandom_range(0, 99) < 13) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		mode    <= op;
		value   <= v;
		restart <= rs;
		do @(posedge clk); while (busy !== 1'b0);
		apply_to_model(op, v, rs);
		transfers_sent++;
	endtask

	// query target: mostly a loaded element, else a neighbour or anything
	function automatic logic signed [VAL_W-1:0] pick_target();
		longint t;
		if (model_count == 0)
			return $urandom;
		t = model_elems[$urandom_range(0, model_count - 1)];
		case ($urandom_range(0, 7))
			5: t = t - 1;
			6: t = t + 1;
			7: t = longint'(int'($urandom));
			default: ;
		endcase
		return VAL_W'(t);
	endfunction

	// compare each answer with the oldest expectation
	always @(posedge clk) begin : check_answers
		search_answer_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result: first_index %0d last_index %0d overflowed %0b",
				       first_index, last_index, overflowed);
				mismatch_count++;
			end else begin
				want = pending_answers.pop_front();
				answers_checked++;
				if (first_index !== want.first) begin
					$error("first_index: expected %0d, got %0d", want.first, first_index);
					mismatch_count++;
				end
				if (last_index !== want.last) begin
					$error("last_index: expected %0d, got %0d", want.last, last_index);
					mismatch_count++;
				end
				if (overflowed !== want.ovf) begin
					$error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
					mismatch_count++;
				end
			end
		end
	end

	// empty store, value extremes, duplicate runs, absent targets, unsorted store
	task automatic test_edges_and_duplicates();
		send_transfer(srs_pkg::MODE_QUERY, '0, 1'b1);
		send_transfer(srs_pkg::MODE_APPEND, VAL_MIN, 1'b1);
		send_transfer(srs_pkg::MODE_QUERY, VAL_MIN, 1'b0);
		send_transfer(srs_pkg::MODE_APPEND, VAL_MIN, 1'b0);
		repeat (3) send_transfer(srs_pkg::MODE_APPEND, -32'sd5, 1'b0);
		send_transfer(srs_pkg::MODE_APPEND, 32'sd0, 1'b0);
		repeat (2) send_transfer(srs_pkg::MODE_APPEND, 32'sd7, 1'b0);
		repeat (2) send_transfer(srs_pkg::MODE_APPEND, VAL_MAX, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, VAL_MIN, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, -32'sd5, 1'b1);
		send_transfer(srs_pkg::MODE_QUERY, 32'sd7, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, VAL_MAX, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, -32'sd4, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, 32'sd1, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, VAL_MAX - 1, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, VAL_MIN + 1, 1'b0);
		// restart empties the store before the new element
		send_transfer(srs_pkg::MODE_APPEND, 32'sd42, 1'b1);
		send_transfer(srs_pkg::MODE_QUERY, 32'sd42, 1'b0);
		// order broken on purpose
		send_transfer(srs_pkg::MODE_APPEND, 32'sd9, 1'b0);
		send_transfer(srs_pkg::MODE_APPEND, 32'sd3, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, 32'sd3, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, 32'sd42, 1'b0);
	endtask

	// fill the store, overrun it, query across it, then clear the sticky flag
	task automatic test_store_full();
		int i;
		for (i = 0; i < STORE_DEPTH + 3; i++) begin
			// long stretch with the sender never pausing
			gaps_on = !(i >= 300 && i < 700);
			send_transfer(srs_pkg::MODE_APPEND, -32'sd3000 + (i / 4) * 5, i == 0);
		end
		gaps_on = 1'b1;
		send_transfer(srs_pkg::MODE_QUERY, -32'sd3000, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, -32'sd3000 + ((STORE_DEPTH - 1) / 4) * 5, 1'b0);
		send_transfer(srs_pkg::MODE_QUERY, -32'sd3000 + (STORE_DEPTH / 8) * 5, 1'b1);
		send_transfer(srs_pkg::MODE_QUERY, -32'sd2999, 1'b0);
		send_transfer(srs_pkg::MODE_APPEND, 32'sd5, 1'b1);
		send_transfer(srs_pkg::MODE_QUERY, 32'sd5, 1'b0);
	endtask

	// sorted runs with random content and queries, plus unconstrained noise
	task automatic test_random_traffic();
		int     base_sent;
		int     n;
		int     i;
		longint cur;
		longint step;
		logic   op;
		base_sent = transfers_sent;
		while (transfers_sent - base_sent < 50) begin
			if ($urandom_range(0, 99) < 12) begin
				repeat ($urandom_range(1, 6)) begin
					op = ($urandom_range(0, 1) == 1) ? srs_pkg::MODE_QUERY
					                                 : srs_pkg::MODE_APPEND;
					send_transfer(op, $urandom,
					              (op == srs_pkg::MODE_QUERY) ? $urandom_range(0, 1) == 1
					                                          : $urandom_range(0, 9) == 0);
				end
			end else begin
				n = $urandom_range(1, 24);
				case ($urandom_range(0, 3))
					0: cur = longint'($urandom_range(0, 20)) - 64'sd2147483648;
					1: cur = 64'sd2147483647 - longint'($urandom_range(0, 3 * n));
					default: cur = longint'(int'($urandom));
				endcase
				for (i = 0; i < n; i++) begin
					send_transfer(srs_pkg::MODE_APPEND, VAL_W'(cur), i == 0);
					if ($urandom_range(0, 9) == 0)
						send_transfer(srs_pkg::MODE_QUERY, pick_target(), 1'b0);
					case ($urandom_range(0, 5))
						0, 1: step = 0;
						2, 3, 4: step = $urandom_range(1, 3);
						default: step = $urandom_range(4, 100000);
					endcase
					if (cur + step > 64'sd2147483647)
						step = 0;
					cur = cur + step;
				end
				repeat ($urandom_range(1, 8))
					send_transfer(srs_pkg::MODE_QUERY, pick_target(), $urandom_range(0, 1) == 1);
			end
		end
	endtask

	// reset, run the tests in turn, drain and report
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges_and_duplicates();
		test_store_full();
		test_random_traffic();
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("run covered %0d transfers and %0d checked query answers", transfers_sent,
		         answers_checked);
		$display("%0d appends were dropped on a full store", appends_dropped);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
